FILE: hdl/rbd_pkg.sv
// shared types and codes for the ring buffer deque
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

    // sizes fixed by the port widths of the deque unit
    localparam int CAPACITY      = 16;
    localparam int ELEMENT_WIDTH = 32;

    typedef enum logic [3:0] {
        REQ_PUSH_FRONT = 4'd0,
        REQ_PUSH_BACK  = 4'd1,
        REQ_POP_FRONT  = 4'd2,
        REQ_POP_BACK   = 4'd3,
        REQ_INSERT     = 4'd4,
        REQ_REMOVE     = 4'd5,
        REQ_GET        = 4'd6,
        REQ_SET        = 4'd7,
        REQ_SWAP       = 4'd8,
        REQ_REVERSE    = 4'd9,
        REQ_SORT       = 4'd10,
        REQ_SEARCH     = 4'd11,
        REQ_CLEAR      = 4'd12
    } req_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_RANGE = 3'd1,
        ST_FULL  = 3'd2,
        ST_EMPTY = 3'd3,
        ST_NOKEY = 3'd4
    } status_t;

endpackage

`default_nettype wire

FILE: hdl/ring_buffer_deque_unit.sv
// ring buffer deque: one transaction in, one result transaction out per request
// push_back, pops, set, clear and errors go straight to the finish state; get and push_front
// pass through one extra state; insert/remove walk the shifted elements, swap/reverse walk pairs,
// sort and search walk their compares; all walks share the one read and one write port of the store
// throughput: one request at a time, in_stall is high until the result is queued
// reset: rst_n clears head, count and handshake state; the store itself is not cleared
// depends on rbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ring_buffer_deque_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  req_type,
    input  wire logic [4:0]  position,
    input  wire logic [3:0]  other_position,
    input  wire logic [31:0] word_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [31:0]      word_out,
    output logic [3:0]       found_position,
    output logic [4:0]       occupancy
);

    localparam int CAPACITY = rbd_pkg::CAPACITY;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 5) ? CW : 5;
    localparam int EW = rbd_pkg::ELEMENT_WIDTH;

    typedef enum logic [4:0] {
        S_IDLE, S_PF_WR, S_SH_RD, S_SH_WR, S_RM_RD, S_RM_WR, S_GET_W,
        S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB, S_SO_CHK, S_SO_V, S_SO_RJ,
        S_SO_CMP, S_SO_PUT, S_BS_CHK, S_BS_CMP, S_FIN
    } state_t;

    state_t             state_reg;
    logic [AW-1:0]      head_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      j_reg;
    logic [AW-1:0]      mid_reg;
    logic [EW-1:0]      v_reg;
    logic               rev_reg;
    rbd_pkg::status_t   res_status_reg;
    logic [31:0]        res_word_reg;
    logic [3:0]         res_found_reg;
    logic               out_valid_reg;
    logic [2:0]         status_reg;
    logic [31:0]        word_out_reg;
    logic [3:0]         found_reg;
    logic [4:0]         occupancy_reg;

    logic [EW-1:0]      store_reg [CAPACITY];
    logic [EW-1:0]      rd_data_reg;

    logic               mem_re;
    logic               mem_we;
    logic [CW-1:0]      rd_log;
    logic [CW-1:0]      wr_log;
    logic [EW-1:0]      wr_data;

    logic               full;
    logic               empty;
    logic               pos_lt;
    logic               pos_le;
    logic               opos_lt;
    logic [CW-1:0]      pos_l;
    logic [AW-1:0]      head_dec;
    logic [AW-1:0]      head_inc;
    logic [EW-1:0]      key;
    logic [CW-1:0]      mid_c;
    rbd_pkg::req_t      req;

    // logical index to physical slot
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] lg);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(lg);
        if (s >= (CW+1)'(CAPACITY))
        begin
            s = s - (CW+1)'(CAPACITY);
        end
        return AW'(s);
    endfunction

    assign req      = rbd_pkg::req_t'(req_type);
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign pos_lt   = XW'(position) < XW'(count_reg);
    assign pos_le   = XW'(position) <= XW'(count_reg);
    assign opos_lt  = XW'(other_position) < XW'(count_reg);
    assign pos_l    = CW'(position);
    assign head_dec = (head_reg == '0) ? AW'(CAPACITY - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == AW'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;
    assign key      = EW'(word_in);
    assign mid_c    = i_reg + ((j_reg - 1'b1 - i_reg) >> 1);

    // single read port and single write port of the element store
    always_comb
    begin
        mem_re  = 1'b0;
        mem_we  = 1'b0;
        rd_log  = '0;
        wr_log  = '0;
        wr_data = v_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (req)
                        rbd_pkg::REQ_PUSH_BACK:
                        begin
                            mem_we  = !full;
                            wr_log  = count_reg;
                            wr_data = key;
                        end
                        rbd_pkg::REQ_SET:
                        begin
                            mem_we  = pos_lt;
                            wr_log  = pos_l;
                            wr_data = key;
                        end
                        rbd_pkg::REQ_GET:
                        begin
                            mem_re = pos_lt;
                            rd_log = pos_l;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_PF_WR:
            begin
                mem_we = 1'b1;
            end
            S_SH_RD:
            begin
                if (i_reg > j_reg)
                begin
                    mem_re = 1'b1;
                    rd_log = i_reg - 1'b1;
                end
                else
                begin
                    mem_we = 1'b1;
                    wr_log = j_reg;
                end
            end
            S_SH_WR, S_RM_WR, S_SW_WA:
            begin
                mem_we  = 1'b1;
                wr_log  = i_reg;
                wr_data = rd_data_reg;
            end
            S_RM_RD:
            begin
                mem_re = ({1'b0, i_reg} + 1'b1) < {1'b0, count_reg};
                rd_log = i_reg + 1'b1;
            end
            S_SW_RA:
            begin
                mem_re = 1'b1;
                rd_log = i_reg;
            end
            S_SW_RB:
            begin
                mem_re = 1'b1;
                rd_log = j_reg;
            end
            S_SW_WB, S_SO_PUT:
            begin
                mem_we = 1'b1;
                wr_log = j_reg;
            end
            S_SO_CHK:
            begin
                mem_re = i_reg < count_reg;
                rd_log = i_reg;
            end
            S_SO_RJ:
            begin
                mem_re = (j_reg != '0);
                rd_log = j_reg - 1'b1;
            end
            S_SO_CMP:
            begin
                mem_we  = rd_data_reg > v_reg;
                wr_log  = j_reg;
                wr_data = rd_data_reg;
            end
            S_BS_CHK:
            begin
                mem_re = i_reg < j_reg;
                rd_log = mid_c;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_reg[slot_of(head_reg, wr_log)] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= store_reg[slot_of(head_reg, rd_log)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            mid_reg        <= '0;
            v_reg          <= '0;
            rev_reg        <= 1'b0;
            res_status_reg <= rbd_pkg::ST_OK;
            res_word_reg   <= '0;
            res_found_reg  <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= '0;
            word_out_reg   <= '0;
            found_reg      <= '0;
            occupancy_reg  <= '0;
        end
        else
        begin
            // the finish state reloads the result register itself
            if (out_valid_reg && !out_stall && (state_reg != S_FIN))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        res_status_reg <= rbd_pkg::ST_OK;
                        res_word_reg   <= '0;
                        res_found_reg  <= '0;
                        v_reg          <= key;
                        state_reg      <= S_FIN;
                        unique case (req)
                            rbd_pkg::REQ_PUSH_FRONT:
                            begin
                                if (full)
                                begin
                                    res_status_reg <= rbd_pkg::ST_FULL;
                                end
                                else
                                begin
                                    if (!empty)
                                    begin
                                        head_reg <= head_dec;
                                    end
                                    count_reg <= count_reg + 1'b1;
                                    state_reg <= S_PF_WR;
                                end
                            end
                            rbd_pkg::REQ_INSERT:
                            begin
                                if (!pos_le)
                                begin
                                    res_status_reg <= rbd_pkg::ST_RANGE;
                                end
                                else if (full)
                                begin
                                    res_status_reg <= rbd_pkg::ST_FULL;
                                end
                                else if (position == '0)
                                begin
                                    if (!empty)
                                    begin
                                        head_reg <= head_dec;
                                    end
                                    count_reg <= count_reg + 1'b1;
                                    state_reg <= S_PF_WR;
                                end
                                else
                                begin
                                    i_reg     <= count_reg;
                                    j_reg     <= pos_l;
                                    state_reg <= S_SH_RD;
                                end
                            end
                            rbd_pkg::REQ_PUSH_BACK:
                            begin
                                if (full)
                                begin
                                    res_status_reg <= rbd_pkg::ST_FULL;
                                end
                                else
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            rbd_pkg::REQ_POP_FRONT:
                            begin
                                if (empty)
                                begin
                                    res_status_reg <= rbd_pkg::ST_EMPTY;
                                end
                                else
                                begin
                                    count_reg <= count_reg - 1'b1;
                                    if (count_reg != CW'(1))
                                    begin
                                        head_reg <= head_inc;
                                    end
                                end
                            end
                            rbd_pkg::REQ_POP_BACK:
                            begin
                                if (empty)
                                begin
                                    res_status_reg <= rbd_pkg::ST_EMPTY;
                                end
                                else
                                begin
                                    count_reg <= count_reg - 1'b1;
                                end
                            end
                            rbd_pkg::REQ_REMOVE:
                            begin
                                if (!pos_lt)
                                begin
                                    res_status_reg <= rbd_pkg::ST_RANGE;
                                end
                                else if (position == '0)
                                begin
                                    count_reg <= count_reg - 1'b1;
                                    if (count_reg != CW'(1))
                                    begin
                                        head_reg <= head_inc;
                                    end
                                end
                                else
                                begin
                                    i_reg     <= pos_l;
                                    state_reg <= S_RM_RD;
                                end
                            end
                            rbd_pkg::REQ_GET:
                            begin
                                if (!pos_lt)
                                begin
                                    res_status_reg <= rbd_pkg::ST_RANGE;
                                end
                                else
                                begin
                                    state_reg <= S_GET_W;
                                end
                            end
                            rbd_pkg::REQ_SET:
                            begin
                                if (!pos_lt)
                                begin
                                    res_status_reg <= rbd_pkg::ST_RANGE;
                                end
                            end
                            rbd_pkg::REQ_SWAP:
                            begin
                                if (!pos_lt || !opos_lt)
                                begin
                                    res_status_reg <= rbd_pkg::ST_RANGE;
                                end
                                else if (XW'(position) != XW'(other_position))
                                begin
                                    i_reg     <= pos_l;
                                    j_reg     <= CW'(other_position);
                                    rev_reg   <= 1'b0;
                                    state_reg <= S_SW_RA;
                                end
                            end
                            rbd_pkg::REQ_REVERSE:
                            begin
                                if (count_reg > CW'(1))
                                begin
                                    i_reg     <= '0;
                                    j_reg     <= count_reg - 1'b1;
                                    rev_reg   <= 1'b1;
                                    state_reg <= S_SW_RA;
                                end
                            end
                            rbd_pkg::REQ_SORT:
                            begin
                                i_reg     <= CW'(1);
                                state_reg <= S_SO_CHK;
                            end
                            rbd_pkg::REQ_SEARCH:
                            begin
                                res_status_reg <= rbd_pkg::ST_NOKEY;
                                i_reg          <= '0;
                                j_reg          <= count_reg;
                                state_reg      <= S_BS_CHK;
                            end
                            rbd_pkg::REQ_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_PF_WR:
                begin
                    state_reg <= S_FIN;
                end
                S_SH_RD:
                begin
                    if (i_reg > j_reg)
                    begin
                        state_reg <= S_SH_WR;
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_FIN;
                    end
                end
                S_SH_WR:
                begin
                    i_reg     <= i_reg - 1'b1;
                    state_reg <= S_SH_RD;
                end
                S_RM_RD:
                begin
                    if (({1'b0, i_reg} + 1'b1) < {1'b0, count_reg})
                    begin
                        state_reg <= S_RM_WR;
                    end
                    else
                    begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_FIN;
                    end
                end
                S_RM_WR:
                begin
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= S_RM_RD;
                end
                S_GET_W:
                begin
                    res_word_reg <= 32'(rd_data_reg);
                    state_reg    <= S_FIN;
                end
                S_SW_RA:
                begin
                    state_reg <= S_SW_RB;
                end
                S_SW_RB:
                begin
                    v_reg     <= rd_data_reg;
                    state_reg <= S_SW_WA;
                end
                S_SW_WA:
                begin
                    state_reg <= S_SW_WB;
                end
                S_SW_WB:
                begin
                    // reverse walks inward until the pointers meet
                    if (rev_reg && (({1'b0, i_reg} + 2'd2) < {1'b0, j_reg}))
                    begin
                        i_reg     <= i_reg + 1'b1;
                        j_reg     <= j_reg - 1'b1;
                        state_reg <= S_SW_RA;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_SO_CHK:
                begin
                    state_reg <= (i_reg < count_reg) ? S_SO_V : S_FIN;
                end
                S_SO_V:
                begin
                    v_reg     <= rd_data_reg;
                    j_reg     <= i_reg;
                    state_reg <= S_SO_RJ;
                end
                S_SO_RJ:
                begin
                    state_reg <= (j_reg != '0) ? S_SO_CMP : S_SO_PUT;
                end
                S_SO_CMP:
                begin
                    if (rd_data_reg > v_reg)
                    begin
                        j_reg     <= j_reg - 1'b1;
                        state_reg <= S_SO_RJ;
                    end
                    else
                    begin
                        state_reg <= S_SO_PUT;
                    end
                end
                S_SO_PUT:
                begin
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= S_SO_CHK;
                end
                S_BS_CHK:
                begin
                    // window is lo in i_reg, exclusive hi in j_reg
                    if (i_reg < j_reg)
                    begin
                        mid_reg   <= AW'(mid_c);
                        state_reg <= S_BS_CMP;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_BS_CMP:
                begin
                    if (v_reg > rd_data_reg)
                    begin
                        i_reg     <= CW'(mid_reg) + 1'b1;
                        state_reg <= S_BS_CHK;
                    end
                    else if (v_reg < rd_data_reg)
                    begin
                        j_reg     <= CW'(mid_reg);
                        state_reg <= S_BS_CHK;
                    end
                    else
                    begin
                        res_status_reg <= rbd_pkg::ST_OK;
                        res_word_reg   <= 32'(rd_data_reg);
                        res_found_reg  <= 4'(mid_reg);
                        state_reg      <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= res_status_reg;
                        word_out_reg  <= res_word_reg;
                        found_reg     <= res_found_reg;
                        occupancy_reg <= 5'(count_reg);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign word_out       = word_out_reg;
    assign found_position = found_reg;
    assign occupancy      = occupancy_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BS_CHK |-> (i_reg <= j_reg) && (j_reg <= count_reg))
        else $error("search window out of order");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result raised outside finish state");

endmodule

`default_nettype wire

FILE: tb/sv/tb_ring_buffer_deque_unit.sv
// testbench for ring_buffer_deque_unit: random and directed deque requests,
// every result checked against a behavioral deque kept in the bench
// depends on rbd_pkg and ring_buffer_deque_unit
`timescale 1ns / 1ps

module tb_ring_buffer_deque_unit;

    localparam int DEPTH = 16;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] word;
        logic [3:0]  found;
        logic [4:0]  occ;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [3:0]  req_type = 4'd0;
    logic [4:0]  position = 5'd0;
    logic [3:0]  other_position = 4'd0;
    logic [31:0] word_in = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [31:0] word_out;
    logic [3:0]  found_position;
    logic [4:0]  occupancy;

    // deque mirror, kept in logical order
    logic [31:0] deque_words[$];
    answer_t     pending_answers[$];
    int          mismatch_count = 0;
    int          sent_count = 0;
    int          checked_count = 0;

    always #4 clk = ~clk;

    ring_buffer_deque_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .position(position),
        .other_position(other_position), .word_in(word_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .word_out(word_out),
        .found_position(found_position), .occupancy(occupancy)
    );

    function automatic answer_t apply_request(logic [3:0] rq, logic [4:0] p, logic [3:0] q,
                                              logic [31:0] w);
        answer_t a;
        int n;
        int lo;
        int hi;
        int mid;
        logic [31:0] t;
        a = '0;
        a.status = rbd_pkg::ST_OK;
        n = deque_words.size();
        case (rq)
            rbd_pkg::REQ_PUSH_FRONT:
                if (n >= DEPTH) a.status = rbd_pkg::ST_FULL;
                else deque_words.push_front(w);
            rbd_pkg::REQ_PUSH_BACK:
                if (n >= DEPTH) a.status = rbd_pkg::ST_FULL;
                else deque_words.push_back(w);
            rbd_pkg::REQ_POP_FRONT:
                if (n == 0) a.status = rbd_pkg::ST_EMPTY;
                else t = deque_words.pop_front();
            rbd_pkg::REQ_POP_BACK:
                if (n == 0) a.status = rbd_pkg::ST_EMPTY;
                else t = deque_words.pop_back();
            rbd_pkg::REQ_INSERT:
                if (p > n) a.status = rbd_pkg::ST_RANGE;
                else if (n >= DEPTH) a.status = rbd_pkg::ST_FULL;
                else deque_words.insert(p, w);
            rbd_pkg::REQ_REMOVE:
                if (p >= n) a.status = rbd_pkg::ST_RANGE;
                else deque_words.delete(p);
            rbd_pkg::REQ_GET:
                if (p >= n) a.status = rbd_pkg::ST_RANGE;
                else a.word = deque_words[p];
            rbd_pkg::REQ_SET:
                if (p >= n) a.status = rbd_pkg::ST_RANGE;
                else deque_words[p] = w;
            rbd_pkg::REQ_SWAP:
                if (p >= n || q >= n) a.status = rbd_pkg::ST_RANGE;
                else
                begin
                    t = deque_words[p];
                    deque_words[p] = deque_words[q];
                    deque_words[q] = t;
                end
            rbd_pkg::REQ_REVERSE: deque_words.reverse();
            rbd_pkg::REQ_SORT: deque_words.sort();
            rbd_pkg::REQ_SEARCH:
            begin
                a.status = rbd_pkg::ST_NOKEY;
                lo = 0;
                hi = n - 1;
                while (lo <= hi)
                begin
                    mid = lo + ((hi - lo) >> 1);
                    if (w > deque_words[mid]) lo = mid + 1;
                    else if (w < deque_words[mid]) hi = mid - 1;
                    else
                    begin
                        a.status = rbd_pkg::ST_OK;
                        a.word = deque_words[mid];
                        a.found = mid[3:0];
                        break;
                    end
                end
            end
            rbd_pkg::REQ_CLEAR: deque_words.delete();
            default: ;
        endcase
        a.occ = 5'(deque_words.size());
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on result %0d: %s got %0h expected %0h", checked_count, what,
                 got, want);
        mismatch_count++;
    endtask

    task automatic pause_cycles();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) n = 0;
        repeat (n) @(negedge clk);
    endtask

    // one transaction on the request side; inputs change on falling edges
    task automatic send_request(logic [3:0] rq, logic [4:0] p, logic [3:0] q, logic [31:0] w);
        pause_cycles();
        req_type = rq;
        position = p;
        other_position = q;
        word_in = w;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_answers.push_back(apply_request(rq, p, q, w));
        sent_count++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // result side: random stalls, check at the accepting rising edge
    initial
    begin
        answer_t e;
        forever
        begin
            @(negedge clk);
            out_stall = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 60) == 0) out_stall = 1'b1;
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_answers.size() == 0)
                begin
                    report_mismatch("unexpected result", 32'd0, 32'd0);
                end
                else
                begin
                    e = pending_answers.pop_front();
                    if (status !== e.status) report_mismatch("status", status, e.status);
                    if (word_out !== e.word) report_mismatch("word_out", word_out, e.word);
                    if (found_position !== e.found)
                        report_mismatch("found_position", found_position, e.found);
                    if (occupancy !== e.occ) report_mismatch("occupancy", occupancy, e.occ);
                end
                checked_count++;
            end
        end
    end

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_ends_and_limits();
        send_request(rbd_pkg::REQ_POP_FRONT, 0, 0, 0);
        send_request(rbd_pkg::REQ_POP_BACK, 0, 0, 0);
        send_request(rbd_pkg::REQ_SEARCH, 0, 0, 32'h5);
        send_request(rbd_pkg::REQ_GET, 0, 0, 0);
        send_request(rbd_pkg::REQ_PUSH_FRONT, 0, 0, 32'hFFFF_FFFF);
        send_request(rbd_pkg::REQ_POP_FRONT, 0, 0, 0);
        for (int i = 0; i < DEPTH; i++)
            send_request(i[0] ? rbd_pkg::REQ_PUSH_BACK : rbd_pkg::REQ_PUSH_FRONT, 0, 0,
                         $urandom);
        send_request(rbd_pkg::REQ_PUSH_BACK, 0, 0, 32'h1);
        send_request(rbd_pkg::REQ_INSERT, 5'd17, 0, 32'h1);
        send_request(rbd_pkg::REQ_INSERT, 5'd3, 0, 32'h1);
        send_request(rbd_pkg::REQ_SWAP, 5'd15, 4'd0, 0);
    endtask

    task automatic test_middle_ops();
        send_request(rbd_pkg::REQ_CLEAR, 0, 0, 0);
        for (int i = 0; i < 6; i++)
            send_request(rbd_pkg::REQ_INSERT, 5'(i / 2), 0, random_word());
        send_request(rbd_pkg::REQ_INSERT, 5'd6, 0, 32'h8000_0000);
        send_request(rbd_pkg::REQ_REMOVE, 5'd2, 0, 0);
        send_request(rbd_pkg::REQ_REMOVE, 5'd0, 0, 0);
        send_request(rbd_pkg::REQ_REMOVE, 5'd16, 0, 0);
        send_request(rbd_pkg::REQ_SET, 5'd1, 0, 32'h1234_5678);
        send_request(rbd_pkg::REQ_SET, 5'd31, 0, 0);
        send_request(rbd_pkg::REQ_GET, 5'd1, 0, 0);
        send_request(rbd_pkg::REQ_SWAP, 5'd0, 4'd4, 0);
        send_request(rbd_pkg::REQ_SWAP, 5'd2, 4'd2, 0);
        send_request(rbd_pkg::REQ_SWAP, 5'd0, 4'd15, 0);
        send_request(rbd_pkg::REQ_REVERSE, 0, 0, 0);
        send_request(rbd_pkg::REQ_SORT, 0, 0, 0);
        send_request(rbd_pkg::REQ_SEARCH, 0, 0, 32'h1234_5678);
        send_request(rbd_pkg::REQ_SEARCH, 0, 0, 32'h1234_5679);
        send_request(4'd13, 5'd31, 4'd15, 32'hFFFF_FFFF);
        send_request(4'd15, 0, 0, 0);
    endtask

    task automatic test_random_traffic(int count);
        logic [3:0] rq;
        int n;
        for (int k = 0; k < count; k++)
        begin
            n = deque_words.size();
            rq = 4'($urandom_range(0, 12));
            // favor searches on sorted contents and drift toward moderate fill
            if (rq == rbd_pkg::REQ_CLEAR && $urandom_range(0, 3) != 0)
                rq = rbd_pkg::REQ_PUSH_BACK;
            if (rq == rbd_pkg::REQ_SEARCH && $urandom_range(0, 1))
                send_request(rbd_pkg::REQ_SORT, 0, 0, 0);
            if ($urandom_range(0, 15) == 0) rq = 4'(13 + $urandom_range(0, 2));
            if (rq == rbd_pkg::REQ_SEARCH && n > 0 && $urandom_range(0, 1))
                send_request(rq, 5'($urandom_range(0, 31)), 4'($urandom),
                             deque_words[$urandom_range(0, n - 1)]);
            else if ($urandom_range(0, 9) == 0)
                send_request(rq, 5'($urandom_range(0, 31)), 4'($urandom), random_word());
            else
                send_request(rq, 5'($urandom_range(0, n)),
                             4'($urandom_range(0, n > 0 ? n - 1 : 0)), random_word());
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_ends_and_limits();
        test_middle_ops();
        test_random_traffic(1300);
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("sent %0d deque requests, checked %0d results", sent_count, checked_count);
        $display("covered pushes, pops, middle edits, swap, reverse, sort, search, clear");
        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("** ring_buffer_deque_unit: PASSED **");
        else
            $display("** ring_buffer_deque_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("timeout after %0d results", checked_count);
        $display("** ring_buffer_deque_unit: FAILED **");
        $finish;
    end
endmodule
